// File: hdl/fba_pkg.sv
// Package for the frame bump allocator: action and status codes, statistic
// indexes, fixed field widths and parameter defaults.
// No dependencies; imported by fba_core and frame_bump_allocator_top.
`default_nettype none

package fba_pkg;

    localparam int ARENA_ADDR_BITS_DEF = 20;
    localparam int COUNTER_BITS_DEF    = 32;
    localparam int REQUEST_BITS_DEF    = 24;

    localparam int ACTION_W     = 3;
    localparam int STATUS_W     = 3;
    localparam int ALIGN_W      = 21;
    localparam int LIVE_W       = 21;
    localparam int STAT_W       = 32;
    localparam int STAT_INDEX_W = 4;

    localparam logic [ACTION_W-1:0] ACT_ALLOC       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE        = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RECLAIM     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_FRAME_RESET = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_STAT   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOREIGN_FREE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LIVE_BLOCKS  = 3'd4;

    localparam logic [STAT_INDEX_W-1:0] SI_CAPACITY      = 4'd0;
    localparam logic [STAT_INDEX_W-1:0] SI_CLAIM_OFFSET  = 4'd1;
    localparam logic [STAT_INDEX_W-1:0] SI_FRAME_PEAK    = 4'd2;
    localparam logic [STAT_INDEX_W-1:0] SI_PAYLOAD       = 4'd3;
    localparam logic [STAT_INDEX_W-1:0] SI_PADDING       = 4'd4;
    localparam logic [STAT_INDEX_W-1:0] SI_CLAIMS        = 4'd5;
    localparam logic [STAT_INDEX_W-1:0] SI_PREV_CLAIMED  = 4'd6;
    localparam logic [STAT_INDEX_W-1:0] SI_PREV_PAYLOAD  = 4'd7;
    localparam logic [STAT_INDEX_W-1:0] SI_PREV_PADDING  = 4'd8;
    localparam logic [STAT_INDEX_W-1:0] SI_PREV_CLAIMS   = 4'd9;
    localparam logic [STAT_INDEX_W-1:0] SI_ALL_TIME_PEAK = 4'd10;
    localparam logic [STAT_INDEX_W-1:0] SI_LIVE_COUNT    = 4'd11;
    localparam logic [STAT_INDEX_W-1:0] SI_FAIL_COUNT    = 4'd12;
    localparam logic [STAT_INDEX_W-1:0] SI_FAIL_REQUEST  = 4'd13;
    localparam logic [STAT_INDEX_W-1:0] SI_FAIL_ALIGN    = 4'd14;
    localparam logic [STAT_INDEX_W-1:0] SI_FAIL_CLAIMED  = 4'd15;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// File: hdl/frame_bump_allocator_top.sv
// Top level of the frame bump allocator: input register, result register
// and handshake control around fba_core. Depends on fba_pkg and fba_core.
//
//   Channel   Prefix  Handshake       Carries
//   request   s_      valid / ready   action, request_bytes, alignment, free_address,
//                                     stat_index
//   result    m_      valid / ready   status, offset, stat_value, claimed_now,
//                                     outstanding_now
//   config    cfg_    write enable    arena size in bytes, no read-back
//
// One request is accepted per cycle while s_ready is high. A request passes through
// the input register and then the result register before its result is on the m_ ports.
// The allocator state is updated as a request moves from the input register to
// the result register. A stalled result holds the input register, and s_ready
// drops only when both registers are full and m_ready is low.
// Reset is synchronous, active low, and sets the capacity to the full arena.
`default_nettype none

module frame_bump_allocator_top
    import fba_pkg::*;
#(
    parameter int ARENA_ADDR_BITS = ARENA_ADDR_BITS_DEF,
    parameter int COUNTER_BITS    = COUNTER_BITS_DEF,
    parameter int REQUEST_BITS    = REQUEST_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [ARENA_ADDR_BITS:0]   cfg_wr_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [ACTION_W-1:0]        s_action,
    input  wire logic [REQUEST_BITS-1:0]    s_request_bytes,
    input  wire logic [ALIGN_W-1:0]         s_alignment,
    input  wire logic [REQUEST_BITS-1:0]    s_free_address,
    input  wire logic [STAT_INDEX_W-1:0]    s_stat_index,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [STATUS_W-1:0]             m_status,
    output logic [ARENA_ADDR_BITS-1:0]      m_offset,
    output logic [STAT_W-1:0]               m_stat_value,
    output logic [ARENA_ADDR_BITS:0]        m_claimed_now,
    output logic [LIVE_W-1:0]               m_outstanding_now
);

    logic                       in_valid_reg;
    logic [ACTION_W-1:0]        action_reg;
    logic [REQUEST_BITS-1:0]    request_bytes_reg;
    logic [ALIGN_W-1:0]         alignment_reg;
    logic [REQUEST_BITS-1:0]    free_address_reg;
    logic [STAT_INDEX_W-1:0]    stat_index_reg;

    logic                       out_valid_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic [ARENA_ADDR_BITS-1:0] offset_reg;
    logic [STAT_W-1:0]          stat_value_reg;
    logic [ARENA_ADDR_BITS:0]   claimed_now_reg;
    logic [LIVE_W-1:0]          outstanding_now_reg;

    logic                       advance;
    logic [STATUS_W-1:0]        status_next;
    logic [ARENA_ADDR_BITS-1:0] offset_next;
    logic [STAT_W-1:0]          stat_value_next;
    logic [ARENA_ADDR_BITS:0]   claimed_now_next;
    logic [LIVE_W-1:0]          outstanding_now_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    fba_core #(
        .ARENA_ADDR_BITS (ARENA_ADDR_BITS),
        .COUNTER_BITS    (COUNTER_BITS),
        .REQUEST_BITS    (REQUEST_BITS)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .fire            (advance),
        .action          (action_reg),
        .request_bytes   (request_bytes_reg),
        .alignment       (alignment_reg),
        .free_address    (free_address_reg),
        .stat_index      (stat_index_reg),
        .status          (status_next),
        .offset          (offset_next),
        .stat_value      (stat_value_next),
        .claimed_now     (claimed_now_next),
        .outstanding_now (outstanding_now_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg        <= s_action;
            request_bytes_reg <= s_request_bytes;
            alignment_reg     <= s_alignment;
            free_address_reg  <= s_free_address;
            stat_index_reg    <= s_stat_index;
        end
        if (advance) begin
            status_reg          <= status_next;
            offset_reg          <= offset_next;
            stat_value_reg      <= stat_value_next;
            claimed_now_reg     <= claimed_now_next;
            outstanding_now_reg <= outstanding_now_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = status_reg;
    assign m_offset          = offset_reg;
    assign m_stat_value      = stat_value_reg;
    assign m_claimed_now     = claimed_now_reg;
    assign m_outstanding_now = outstanding_now_reg;

endmodule

`default_nettype wire

// File: hdl/fba_core.sv
// Allocator state and the single-pass decision logic for one transfer.
// Depends on fba_pkg; instantiated by frame_bump_allocator_top.
`default_nettype none

module fba_core
    import fba_pkg::*;
#(
    parameter int ARENA_ADDR_BITS = ARENA_ADDR_BITS_DEF,
    parameter int COUNTER_BITS    = COUNTER_BITS_DEF,
    parameter int REQUEST_BITS    = REQUEST_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [ARENA_ADDR_BITS:0]   cfg_wr_data,
    input  wire logic                       fire,
    input  wire logic [ACTION_W-1:0]        action,
    input  wire logic [REQUEST_BITS-1:0]    request_bytes,
    input  wire logic [ALIGN_W-1:0]         alignment,
    input  wire logic [REQUEST_BITS-1:0]    free_address,
    input  wire logic [STAT_INDEX_W-1:0]    stat_index,
    output logic [STATUS_W-1:0]             status,
    output logic [ARENA_ADDR_BITS-1:0]      offset,
    output logic [STAT_W-1:0]               stat_value,
    output logic [ARENA_ADDR_BITS:0]        claimed_now,
    output logic [LIVE_W-1:0]               outstanding_now
);

    localparam int A  = ARENA_ADDR_BITS;
    localparam int S  = ARENA_ADDR_BITS + 1;
    localparam int C  = COUNTER_BITS;
    localparam int R  = REQUEST_BITS;
    localparam int WW = max2(max2(S, ALIGN_W), R) + 2;
    localparam int PW = max2(C, R) + 1;
    localparam int DW = max2(C, S) + 1;
    localparam int CW = max2(R, S);

    localparam logic [S-1:0]      ARENA_MAX = {1'b1, {A{1'b0}}};
    localparam logic [C-1:0]      COUNT_MAX = {C{1'b1}};
    localparam logic [LIVE_W-1:0] LIVE_MAX  = {LIVE_W{1'b1}};

    logic [S-1:0]      capacity_reg;
    logic [S-1:0]      claim_reg, claim_next;
    logic [S-1:0]      frame_peak_reg, frame_peak_next;
    logic [S-1:0]      all_peak_reg, all_peak_next;
    logic [C-1:0]      payload_reg, payload_next;
    logic [C-1:0]      padding_reg, padding_next;
    logic [C-1:0]      claims_reg, claims_next;
    logic [LIVE_W-1:0] live_reg, live_next;
    logic [C-1:0]      fail_count_reg, fail_count_next;
    logic [S-1:0]      prev_claimed_reg, prev_claimed_next;
    logic [C-1:0]      prev_payload_reg, prev_payload_next;
    logic [C-1:0]      prev_padding_reg, prev_padding_next;
    logic [C-1:0]      prev_claims_reg, prev_claims_next;
    logic [R-1:0]      fail_request_reg, fail_request_next;
    logic [ALIGN_W-1:0] fail_align_reg, fail_align_next;
    logic [S-1:0]      fail_claimed_reg, fail_claimed_next;

    logic [R-1:0]      size;
    logic              pow2;
    logic [WW-1:0]     align_m1;
    logic [WW-1:0]     aligned;
    logic [WW-1:0]     alloc_end;
    logic [WW-1:0]     cap_w;
    logic              alloc_ok;
    logic [S-1:0]      pad;
    logic [PW-1:0]     payload_sum;
    logic [DW-1:0]     padding_sum;
    logic              foreign;
    logic [63:0]       stat_sel;

    always_comb begin
        size      = (request_bytes == '0) ? R'(1) : request_bytes;
        pow2      = (alignment != '0) && ((alignment & (alignment - 1'b1)) == '0);
        align_m1  = WW'(alignment) - WW'(1);
        cap_w     = WW'(capacity_reg);
        aligned   = (WW'(claim_reg) + align_m1) & ~align_m1;
        alloc_end = aligned + WW'(size);
        alloc_ok  = pow2 && (claim_reg <= capacity_reg) && (aligned <= cap_w)
                    && (alloc_end <= cap_w);
        pad       = S'(aligned) - claim_reg;
        payload_sum = PW'(payload_reg) + PW'(request_bytes);
        padding_sum = DW'(padding_reg) + DW'(pad);
        foreign   = CW'(free_address) >= CW'(capacity_reg);
    end

    always_comb begin
        unique case (stat_index)
            SI_CAPACITY:      stat_sel = 64'(capacity_reg);
            SI_CLAIM_OFFSET:  stat_sel = 64'(claim_reg);
            SI_FRAME_PEAK:    stat_sel = 64'(frame_peak_reg);
            SI_PAYLOAD:       stat_sel = 64'(payload_reg);
            SI_PADDING:       stat_sel = 64'(padding_reg);
            SI_CLAIMS:        stat_sel = 64'(claims_reg);
            SI_PREV_CLAIMED:  stat_sel = 64'(prev_claimed_reg);
            SI_PREV_PAYLOAD:  stat_sel = 64'(prev_payload_reg);
            SI_PREV_PADDING:  stat_sel = 64'(prev_padding_reg);
            SI_PREV_CLAIMS:   stat_sel = 64'(prev_claims_reg);
            SI_ALL_TIME_PEAK: stat_sel = 64'(all_peak_reg);
            SI_LIVE_COUNT:    stat_sel = 64'(live_reg);
            SI_FAIL_COUNT:    stat_sel = 64'(fail_count_reg);
            SI_FAIL_REQUEST:  stat_sel = 64'(fail_request_reg);
            SI_FAIL_ALIGN:    stat_sel = 64'(fail_align_reg);
            SI_FAIL_CLAIMED:  stat_sel = 64'(fail_claimed_reg);
            default:          stat_sel = '0;
        endcase
    end

    always_comb begin
        claim_next        = claim_reg;
        frame_peak_next   = frame_peak_reg;
        all_peak_next     = all_peak_reg;
        payload_next      = payload_reg;
        padding_next      = padding_reg;
        claims_next       = claims_reg;
        live_next         = live_reg;
        fail_count_next   = fail_count_reg;
        prev_claimed_next = prev_claimed_reg;
        prev_payload_next = prev_payload_reg;
        prev_padding_next = prev_padding_reg;
        prev_claims_next  = prev_claims_reg;
        fail_request_next = fail_request_reg;
        fail_align_next   = fail_align_reg;
        fail_claimed_next = fail_claimed_reg;
        status            = ST_OK;
        offset            = '0;
        stat_value        = '0;

        case (action)
            ACT_ALLOC: begin
                if (!alloc_ok) begin
                    status            = ST_ALLOC_FAIL;
                    fail_count_next   = (fail_count_reg == COUNT_MAX) ? COUNT_MAX
                                        : fail_count_reg + 1'b1;
                    fail_request_next = request_bytes;
                    fail_align_next   = alignment;
                    fail_claimed_next = claim_reg;
                end else begin
                    payload_next = (payload_sum > PW'(COUNT_MAX)) ? COUNT_MAX
                                   : C'(payload_sum);
                    padding_next = (padding_sum > DW'(COUNT_MAX)) ? COUNT_MAX
                                   : C'(padding_sum);
                    claims_next  = (claims_reg == COUNT_MAX) ? COUNT_MAX
                                   : claims_reg + 1'b1;
                    live_next    = (live_reg == LIVE_MAX) ? LIVE_MAX : live_reg + 1'b1;
                    claim_next   = S'(alloc_end);
                    if (S'(alloc_end) > frame_peak_reg) begin
                        frame_peak_next = S'(alloc_end);
                    end
                    if (S'(alloc_end) > all_peak_reg) begin
                        all_peak_next = S'(alloc_end);
                    end
                    offset = A'(aligned);
                end
            end
            ACT_FREE: begin
                if (foreign) begin
                    status = ST_FOREIGN_FREE;
                end else if (live_reg == '0) begin
                    status = ST_UNDERFLOW;
                end else begin
                    live_next = live_reg - 1'b1;
                end
            end
            ACT_RECLAIM, ACT_FRAME_RESET: begin
                if (live_reg != '0) begin
                    status = ST_LIVE_BLOCKS;
                end else begin
                    claim_next = '0;
                    if (action == ACT_FRAME_RESET) begin
                        prev_claimed_next = frame_peak_reg;
                        prev_payload_next = payload_reg;
                        prev_padding_next = padding_reg;
                        prev_claims_next  = claims_reg;
                        payload_next      = '0;
                        padding_next      = '0;
                        claims_next       = '0;
                        frame_peak_next   = '0;
                    end
                end
            end
            ACT_READ_STAT: begin
                stat_value = stat_sel[STAT_W-1:0];
            end
            default: begin
            end
        endcase

        claimed_now     = claim_next;
        outstanding_now = live_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg     <= ARENA_MAX;
            claim_reg        <= '0;
            frame_peak_reg   <= '0;
            all_peak_reg     <= '0;
            payload_reg      <= '0;
            padding_reg      <= '0;
            claims_reg       <= '0;
            live_reg         <= '0;
            fail_count_reg   <= '0;
            prev_claimed_reg <= '0;
            prev_payload_reg <= '0;
            prev_padding_reg <= '0;
            prev_claims_reg  <= '0;
            fail_request_reg <= '0;
            fail_align_reg   <= '0;
            fail_claimed_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= (cfg_wr_data > ARENA_MAX) ? ARENA_MAX : cfg_wr_data;
            end
            if (fire) begin
                claim_reg        <= claim_next;
                frame_peak_reg   <= frame_peak_next;
                all_peak_reg     <= all_peak_next;
                payload_reg      <= payload_next;
                padding_reg      <= padding_next;
                claims_reg       <= claims_next;
                live_reg         <= live_next;
                fail_count_reg   <= fail_count_next;
                prev_claimed_reg <= prev_claimed_next;
                prev_payload_reg <= prev_payload_next;
                prev_padding_reg <= prev_padding_next;
                prev_claims_reg  <= prev_claims_next;
                fail_request_reg <= fail_request_next;
                fail_align_reg   <= fail_align_next;
                fail_claimed_reg <= fail_claimed_next;
            end
        end
    end

endmodule

`default_nettype wire
